>>> src/avm_pkg.sv
// Shared types and constants for the accumulator VM execute unit.
package avm_pkg;

    localparam int DATA_W = 16;
    localparam int FUNC_W = 4;
    localparam int ERR_W  = 3;

    // Stream payload widths: tdata carries the operands, tuser the opcode
    localparam int S_TDATA_W = 2 * DATA_W;
    localparam int S_TUSER_W = 8;
    localparam int M_TDATA_W = 40;

    typedef enum logic [FUNC_W-1:0] {
        OP_MOV  = 4'd0,
        OP_ADD  = 4'd1,
        OP_SUB  = 4'd2,
        OP_MUL  = 4'd3,
        OP_DIV  = 4'd4,
        OP_MOD  = 4'd5,
        OP_JE   = 4'd6,
        OP_JNE  = 4'd7,
        OP_PUSH = 4'd8,
        OP_POP  = 4'd9,
        OP_INT  = 4'd10
    } op_t;

    localparam logic [ERR_W-1:0] ERR_OK     = 3'd0;
    localparam logic [ERR_W-1:0] ERR_REG    = 3'd1;
    localparam logic [ERR_W-1:0] ERR_OPCODE = 3'd2;
    localparam logic [ERR_W-1:0] ERR_INT    = 3'd3;
    localparam logic [ERR_W-1:0] ERR_DIV0   = 3'd4;
    localparam logic [ERR_W-1:0] ERR_STACK  = 3'd5;
    localparam logic [ERR_W-1:0] ERR_HALTED = 3'd6;

    localparam logic [DATA_W-1:0] INT_PRINT = 16'h0001;
    localparam logic [DATA_W-1:0] INT_HALT  = 16'h0002;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic latch;
        logic exec;
        logic div_step;
        logic wr_a;
        logic wr_b;
        logic wr_ip;
        logic load_out;
    } cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic halted;
        logic need_div;
        logic div_last;
        logic pop_ok;
        logic out_free;
    } stat_t;

endpackage

>>> src/avm_ctrl.sv
// Sequencing state machine of the accumulator VM execute unit.
module avm_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_tvalid,
    output logic           s_tready,
    input  avm_pkg::stat_t stat,
    output avm_pkg::cmd_t  cmd
);
    import avm_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_EXEC  = 7'b0000010,
        S_DIV   = 7'b0000100,
        S_WR_A  = 7'b0001000,
        S_WR_B  = 7'b0010000,
        S_WR_IP = 7'b0100000,
        S_OUT   = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    // Decode the next state and issue commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.latch  = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                cmd.exec = 1'b1;
                if (stat.halted) begin
                    state_next = S_OUT;
                end else if (stat.need_div) begin
                    state_next = S_DIV;
                end else begin
                    state_next = S_WR_A;
                end
            end
            S_DIV: begin
                cmd.div_step = 1'b1;
                if (stat.div_last) begin
                    state_next = S_WR_A;
                end
            end
            S_WR_A: begin
                cmd.wr_a   = 1'b1;
                state_next = stat.pop_ok ? S_WR_B : S_WR_IP;
            end
            S_WR_B: begin
                cmd.wr_b   = 1'b1;
                state_next = S_WR_IP;
            end
            S_WR_IP: begin
                cmd.wr_ip  = 1'b1;
                state_next = S_OUT;
            end
            S_OUT: begin
                if (stat.out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold the state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_tready = (state_reg == S_IDLE);

endmodule

>>> src/avm_dp.sv
// Datapath: register file, stack memory, ALU, iterative divider and result register.
module avm_dp #(
    parameter int NUM_REGS    = 8,
    parameter int STACK_DEPTH = 256,
    parameter int IP_INDEX    = 0,
    parameter int ACC_INDEX   = 1,
    parameter int SP_INDEX    = 2
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  avm_pkg::cmd_t                  cmd,
    output avm_pkg::stat_t                 stat,
    input  logic [avm_pkg::S_TDATA_W-1:0]  s_tdata,
    input  logic [avm_pkg::S_TUSER_W-1:0]  s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [avm_pkg::M_TDATA_W-1:0]  m_tdata
);
    import avm_pkg::*;

    localparam int RIDX_W = $clog2(NUM_REGS);
    localparam int SIDX_W = $clog2(STACK_DEPTH);
    localparam int CNT_W  = $clog2(DATA_W + 1);

    localparam logic [DATA_W-1:0] NREG_D  = DATA_W'(NUM_REGS);
    localparam logic [DATA_W:0]   DEPTH_D = (DATA_W + 1)'(STACK_DEPTH);

    localparam logic IP_OK  = (IP_INDEX < NUM_REGS);
    localparam logic ACC_OK = (ACC_INDEX < NUM_REGS);
    localparam logic SP_OK  = (SP_INDEX < NUM_REGS);

    localparam logic [RIDX_W-1:0] IP_IDX  = RIDX_W'(IP_INDEX);
    localparam logic [RIDX_W-1:0] ACC_IDX = RIDX_W'(ACC_INDEX);
    localparam logic [RIDX_W-1:0] SP_IDX  = RIDX_W'(SP_INDEX);

    localparam logic [CNT_W-1:0] DIV_STEPS = CNT_W'(DATA_W);

    // Instruction latched at acceptance
    logic [FUNC_W-1:0] func_reg;
    logic [DATA_W-1:0] a_reg, b_reg;

    // Register file with valid bits, role shadows
    logic [DATA_W-1:0]   reg_mem [NUM_REGS];
    logic [NUM_REGS-1:0] vld_reg;
    logic [DATA_W-1:0]   rd_a_reg, rd_b_reg;
    logic [DATA_W-1:0]   ip_sh_reg, acc_sh_reg, sp_sh_reg;

    // Stack memory
    logic [DATA_W-1:0] stk_mem [STACK_DEPTH];
    logic [DATA_W-1:0] stk_rd_reg;
    logic [DATA_W-1:0] sp_m1;
    logic              stk_we;

    // Execute results
    logic [ERR_W-1:0]  err_reg;
    logic              print_reg, halt_set_reg, pop_ok_reg;
    logic              exec_ok;
    logic [DATA_W-1:0] nip_reg, res_reg;
    logic              halt_flag_reg;

    // Divider
    logic [DATA_W-1:0] quo_reg, rem_reg, den_reg;
    logic [CNT_W-1:0]  div_cnt_reg;
    logic [DATA_W:0]   div_shift, div_trial;

    // Output register
    logic                 m_valid_reg;
    logic [M_TDATA_W-1:0] m_data_reg;

    // Write port
    logic              wr_en;
    logic [RIDX_W-1:0] wr_idx;
    logic [DATA_W-1:0] wr_data;

    // Execute decode
    logic              a_ok, b_ok, push_flt, pop_flt;
    logic [ERR_W-1:0]  ex_err;
    logic              ex_print, ex_halt, ex_taken, ex_need_div;
    logic [DATA_W-1:0] ex_res;
    logic [2*DATA_W-1:0] prod;
    logic [RIDX_W-1:0] s_a_idx, s_b_idx;

    assign s_a_idx = s_tdata[RIDX_W-1:0];
    assign s_b_idx = s_tdata[DATA_W +: RIDX_W];
    assign sp_m1   = sp_sh_reg - 16'd1;

    // Latch the instruction
    always_ff @(posedge aclk) begin
        if (cmd.latch) begin
            func_reg <= s_tuser[FUNC_W-1:0];
            a_reg    <= s_tdata[DATA_W-1:0];
            b_reg    <= s_tdata[2*DATA_W-1:DATA_W];
        end
    end

    // Register file: one write port, two registered read ports
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            reg_mem[wr_idx] <= wr_data;
        end
        if (cmd.latch) begin
            rd_a_reg <= vld_reg[s_a_idx] ? reg_mem[s_a_idx] : '0;
            rd_b_reg <= vld_reg[s_b_idx] ? reg_mem[s_b_idx] : '0;
        end
    end

    // Mark written entries and track the role registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg    <= '0;
            ip_sh_reg  <= '0;
            acc_sh_reg <= '0;
            sp_sh_reg  <= '0;
        end else if (wr_en) begin
            vld_reg[wr_idx] <= 1'b1;
            if (IP_OK && wr_idx == IP_IDX) begin
                ip_sh_reg <= wr_data;
            end
            if (ACC_OK && wr_idx == ACC_IDX) begin
                acc_sh_reg <= wr_data;
            end
            if (SP_OK && wr_idx == SP_IDX) begin
                sp_sh_reg <= wr_data;
            end
        end
    end

    // Stack: push writes at SP, pop reads below SP
    always_ff @(posedge aclk) begin
        if (stk_we) begin
            stk_mem[sp_sh_reg[SIDX_W-1:0]] <= rd_a_reg;
        end
        if (cmd.latch) begin
            stk_rd_reg <= stk_mem[sp_m1[SIDX_W-1:0]];
        end
    end

    // Decode checks and compute the simple results
    assign a_ok     = (a_reg < NREG_D);
    assign b_ok     = (b_reg < NREG_D);
    assign push_flt = ({1'b0, sp_sh_reg} >= DEPTH_D);
    assign pop_flt  = (sp_sh_reg == '0) || ({1'b0, sp_sh_reg} > DEPTH_D);
    assign prod     = rd_a_reg * rd_b_reg;

    always_comb begin
        ex_err      = ERR_OK;
        ex_print    = 1'b0;
        ex_halt     = 1'b0;
        ex_taken    = 1'b0;
        ex_need_div = 1'b0;
        ex_res      = '0;
        unique case (func_reg)
            OP_MOV: begin
                if (!a_ok) ex_err = ERR_REG;
            end
            OP_ADD, OP_SUB, OP_MUL: begin
                if (!a_ok || !b_ok) ex_err = ERR_REG;
                if (func_reg == OP_ADD) begin
                    ex_res = rd_a_reg + rd_b_reg;
                end else if (func_reg == OP_SUB) begin
                    ex_res = rd_a_reg - rd_b_reg;
                end else begin
                    ex_res = prod[DATA_W-1:0];
                end
            end
            OP_DIV, OP_MOD: begin
                if (!a_ok || !b_ok) begin
                    ex_err = ERR_REG;
                end else if (rd_b_reg == '0) begin
                    ex_err = ERR_DIV0;
                end else begin
                    ex_need_div = 1'b1;
                end
            end
            OP_JE, OP_JNE: begin
                if (!a_ok) begin
                    ex_err = ERR_REG;
                end else begin
                    ex_taken = ((acc_sh_reg == rd_a_reg) == (func_reg == OP_JE));
                end
            end
            OP_PUSH: begin
                if (!a_ok) begin
                    ex_err = ERR_REG;
                end else if (push_flt) begin
                    ex_err = ERR_STACK;
                end
            end
            OP_POP: begin
                if (!a_ok) begin
                    ex_err = ERR_REG;
                end else if (pop_flt) begin
                    ex_err = ERR_STACK;
                end
            end
            OP_INT: begin
                if (a_reg == INT_PRINT) begin
                    ex_print = 1'b1;
                end else if (a_reg == INT_HALT) begin
                    ex_halt = 1'b1;
                end else begin
                    ex_err = ERR_INT;
                end
            end
            default: begin
                ex_err = ERR_OPCODE;
            end
        endcase
        // A stopped machine changes nothing
        if (halt_flag_reg) begin
            ex_err      = ERR_HALTED;
            ex_print    = 1'b0;
            ex_halt     = 1'b0;
            ex_taken    = 1'b0;
            ex_need_div = 1'b0;
        end
    end

    // Capture the execute results
    always_ff @(posedge aclk) begin
        if (cmd.exec) begin
            err_reg      <= ex_err;
            print_reg    <= ex_print;
            halt_set_reg <= ex_halt;
            pop_ok_reg   <= (func_reg == OP_POP) && (ex_err == ERR_OK);
            res_reg      <= ex_res;
            nip_reg      <= ex_taken ? b_reg : ip_sh_reg + 16'd1;
        end
    end

    assign exec_ok = (err_reg == ERR_OK);

    // Restoring divider, one quotient bit per step
    assign div_shift = {rem_reg, quo_reg[DATA_W-1]};
    assign div_trial = div_shift - {1'b0, den_reg};

    always_ff @(posedge aclk) begin
        if (cmd.exec && ex_need_div) begin
            quo_reg <= rd_a_reg;
            rem_reg <= '0;
            den_reg <= rd_b_reg;
        end else if (cmd.div_step) begin
            if (!div_trial[DATA_W]) begin
                rem_reg <= div_trial[DATA_W-1:0];
                quo_reg <= {quo_reg[DATA_W-2:0], 1'b1};
            end else begin
                rem_reg <= div_shift[DATA_W-1:0];
                quo_reg <= {quo_reg[DATA_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            div_cnt_reg <= '0;
        end else if (cmd.exec && ex_need_div) begin
            div_cnt_reg <= DIV_STEPS;
        end else if (cmd.div_step) begin
            div_cnt_reg <= div_cnt_reg - 1'b1;
        end
    end

    // Select the register file write of each commit step
    always_comb begin
        wr_en   = 1'b0;
        wr_idx  = '0;
        wr_data = '0;
        stk_we  = 1'b0;
        if (cmd.wr_a && exec_ok) begin
            unique case (func_reg)
                OP_MOV: begin
                    wr_en   = 1'b1;
                    wr_idx  = a_reg[RIDX_W-1:0];
                    wr_data = b_reg;
                end
                OP_ADD, OP_SUB, OP_MUL: begin
                    wr_en   = ACC_OK;
                    wr_idx  = ACC_IDX;
                    wr_data = res_reg;
                end
                OP_DIV: begin
                    wr_en   = ACC_OK;
                    wr_idx  = ACC_IDX;
                    wr_data = quo_reg;
                end
                OP_MOD: begin
                    wr_en   = ACC_OK;
                    wr_idx  = ACC_IDX;
                    wr_data = rem_reg;
                end
                OP_PUSH: begin
                    stk_we  = 1'b1;
                    wr_en   = SP_OK;
                    wr_idx  = SP_IDX;
                    wr_data = sp_sh_reg + 16'd1;
                end
                OP_POP: begin
                    wr_en   = SP_OK;
                    wr_idx  = SP_IDX;
                    wr_data = sp_m1;
                end
                default: begin
                end
            endcase
        end else if (cmd.wr_b && exec_ok) begin
            wr_en   = 1'b1;
            wr_idx  = a_reg[RIDX_W-1:0];
            wr_data = stk_rd_reg;
        end else if (cmd.wr_ip) begin
            wr_en   = IP_OK;
            wr_idx  = IP_IDX;
            wr_data = nip_reg;
        end
    end

    // Set the halt flag as the instruction retires
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            halt_flag_reg <= 1'b0;
        end else if (cmd.wr_ip && halt_set_reg) begin
            halt_flag_reg <= 1'b1;
        end
    end

    // Result register: load when free, drop when taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.load_out) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            m_data_reg <= {3'b000, err_reg, halt_flag_reg, print_reg, acc_sh_reg, ip_sh_reg};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    assign stat.halted   = halt_flag_reg;
    assign stat.need_div = ex_need_div;
    assign stat.div_last = (div_cnt_reg == CNT_W'(1));
    assign stat.pop_ok   = pop_ok_reg;
    assign stat.out_free = !m_valid_reg || m_tready;

    a_halt_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        halt_flag_reg |=> halt_flag_reg)
        else $error("halt flag cleared while running");

    a_halt_no_write: assert property (@(posedge aclk) disable iff (!aresetn)
        halt_flag_reg |-> !wr_en && !stk_we)
        else $error("state written after halt");

    a_load_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |-> stat.out_free)
        else $error("result register overwritten before taken");

    a_div_count: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.div_step |-> div_cnt_reg != '0)
        else $error("divide step without a pending iteration");

endmodule

>>> src/accumulator_vm_execute_unit.sv
// Each instruction runs execute, divide steps for div/mod, the register write, a pop's
// register load, the IP write and the result load; a halted machine skips to the load.
// One instruction at a time; the next is accepted the cycle after the result register
// loads; the 16-step restoring divider and single register file write port set the pace.
// Reset: synchronous active-low aresetn clears the register file valid bits, role
// registers, halt flag and control at once; stack contents stay undefined until pushed.
module accumulator_vm_execute_unit #(
    parameter int NUM_REGS    = 8,
    parameter int STACK_DEPTH = 256,
    parameter int IP_INDEX    = 0,
    parameter int ACC_INDEX   = 1,
    parameter int SP_INDEX    = 2
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // s_tdata: first_operand[15:0], second_operand[31:16]
    input  logic [avm_pkg::S_TDATA_W-1:0] s_tdata,
    // s_tuser: func[3:0], zero fill [7:4]
    input  logic [avm_pkg::S_TUSER_W-1:0] s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // m_tdata: next_ip[15:0], acc_value[31:16], print_valid[32], halted[33],
    //          error_code[36:34], zero fill [39:37]
    output logic [avm_pkg::M_TDATA_W-1:0] m_tdata
);
    import avm_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    avm_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    avm_dp #(
        .NUM_REGS    (NUM_REGS),
        .STACK_DEPTH (STACK_DEPTH),
        .IP_INDEX    (IP_INDEX),
        .ACC_INDEX   (ACC_INDEX),
        .SP_INDEX    (SP_INDEX)
    ) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .stat     (stat),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule
